/* rtl/fpa_pkg.sv */
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared constants, types and codes for the fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int WORD_BITS     = 32;
  localparam int FRACTION_BITS = 8;

  // divide numerator |a| << (F+1) plus |b|, also the quotient width
  localparam int NUM_W     = WORD_BITS + FRACTION_BITS + 1;
  localparam int MAG_W     = (2 * WORD_BITS > NUM_W) ? 2 * WORD_BITS : NUM_W;
  localparam int DIV_CNT_W = $clog2(NUM_W + 1);

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        umag_t;
  typedef logic [MAG_W-1:0]            mag_t;

  localparam word_t WORD_MAX = word_t'({1'b0, {(WORD_BITS-1){1'b1}}});
  localparam word_t WORD_MIN = word_t'({1'b1, {(WORD_BITS-1){1'b0}}});

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_INC,
    OP_DEC, OP_CMP, OP_MIN, OP_FROM_INT, OP_TO_INT
  } op_t;

  typedef enum logic [1:0] {
    ST_OK, ST_SAT, ST_DIV0
  } status_t;

  typedef struct packed {
    logic lt;
    logic eq;
    logic gt;
  } cmp_t;

  typedef struct packed {
    op_t   op;
    word_t a;
    word_t b;
    umag_t mag_a;
    umag_t mag_b;
    logic  neg;
    cmp_t  cmp;
  } item_t;

endpackage

/* rtl/fpa_front.sv */
// ----------------------------------------------------------------------------
// fpa_front
// Accepts items, narrows operands to the word, compares them and takes
// magnitudes and result sign, then hands the item to the queue.
// ----------------------------------------------------------------------------
module fpa_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         op,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               q_push,
  output fpa_pkg::item_t     q_item,
  input  logic               q_full
);

  localparam int W = fpa_pkg::WORD_BITS;

  fpa_pkg::word_t a;
  fpa_pkg::word_t b;
  fpa_pkg::item_t item_next;
  fpa_pkg::item_t item;
  logic           valid;
  logic           accept;

  always_comb begin
    a = fpa_pkg::word_t'(operand_a[W-1:0]);
    b = fpa_pkg::word_t'(operand_b[W-1:0]);
    item_next.op     = fpa_pkg::op_t'(op);
    item_next.a      = a;
    item_next.b      = b;
    item_next.mag_a  = a[W-1] ? fpa_pkg::umag_t'(0) - fpa_pkg::umag_t'(a) : fpa_pkg::umag_t'(a);
    item_next.mag_b  = b[W-1] ? fpa_pkg::umag_t'(0) - fpa_pkg::umag_t'(b) : fpa_pkg::umag_t'(b);
    item_next.neg    = (fpa_pkg::op_t'(op) == fpa_pkg::OP_FROM_INT) ? a[W-1] : (a[W-1] ^ b[W-1]);
    item_next.cmp.lt = a < b;
    item_next.cmp.eq = a == b;
    item_next.cmp.gt = a > b;
  end

  assign in_stall = valid && q_full;
  assign accept   = in_valid && !in_stall;
  assign q_push   = valid && !q_full;
  assign q_item   = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (q_push) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= item_next;
    end
  end

endmodule

/* rtl/fpa_queue.sv */
// ----------------------------------------------------------------------------
// fpa_queue
// Two-entry item queue between the front and the back.
// ----------------------------------------------------------------------------
module fpa_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fpa_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output fpa_pkg::item_t head_item
);

  fpa_pkg::item_t mem [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     cnt;

  assign full       = cnt == 2'd2;
  assign head_valid = cnt != 2'd0;
  assign head_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

endmodule

/* rtl/fpa_back.sv */
// ----------------------------------------------------------------------------
// fpa_back
// Execute pipeline: operand stage with a restoring divider, magnitude
// stage (sum, product, quotient, shift or select), round, clamp, out register.
// ----------------------------------------------------------------------------
module fpa_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_valid,
  input  fpa_pkg::item_t     q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_value,
  output logic               a_less,
  output logic               a_equal,
  output logic               a_greater,
  output logic [1:0]         status
);

  localparam int W     = fpa_pkg::WORD_BITS;
  localparam int F     = fpa_pkg::FRACTION_BITS;
  localparam int NUM_W = fpa_pkg::NUM_W;
  localparam int CNT_W = fpa_pkg::DIV_CNT_W;
  localparam fpa_pkg::mag_t HALF    = fpa_pkg::mag_t'(1) << (F - 1);
  localparam fpa_pkg::mag_t LIM_NEG = fpa_pkg::mag_t'(1) << (W - 1);
  localparam fpa_pkg::mag_t LIM_POS = LIM_NEG - fpa_pkg::mag_t'(1);

  // operand stage
  logic           s1_valid;
  fpa_pkg::item_t s1;
  logic           s1_done;
  logic           s1_load;
  // divider
  logic [CNT_W-1:0] div_left;
  logic [W:0]       div_rem;
  logic [W:0]       div_den;
  logic [NUM_W-1:0] div_num;
  logic [W+1:0]     rem_sh;
  logic             rem_ge;
  // magnitude stage
  logic             s2_valid;
  logic             s2_load;
  fpa_pkg::word_t   s2_res, s2_res_next;
  fpa_pkg::status_t s2_st, s2_st_next;
  logic             s2_use_mag, s2_use_mag_next;
  logic             s2_round, s2_round_next;
  logic             s2_neg;
  fpa_pkg::mag_t    s2_mag, s2_mag_next;
  fpa_pkg::cmp_t    s2_cmp;
  logic [2*W-1:0]   prod;
  logic signed [W:0] ea, eb, sum;
  fpa_pkg::word_t   sa;
  // output stage
  logic             out_free;
  fpa_pkg::mag_t    m;
  fpa_pkg::word_t   fin_res;
  fpa_pkg::status_t fin_st;
  fpa_pkg::word_t   out_res;
  fpa_pkg::status_t out_st;
  fpa_pkg::cmp_t    out_cmp;

  assign out_free = !out_valid || !out_stall;
  assign s2_load  = !s2_valid || out_free;
  assign s1_done  = div_left == '0;
  assign s1_load  = !s1_valid || (s1_done && s2_load);
  assign q_pop    = s1_load && q_valid;

  assign rem_sh = {div_rem, div_num[NUM_W-1]};
  assign rem_ge = rem_sh >= {1'b0, div_den};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      div_left <= '0;
    end else begin
      if (s1_load) begin
        s1_valid <= q_valid;
      end
      if (q_pop) begin
        div_left <= (q_item.op == fpa_pkg::OP_DIV && q_item.mag_b != '0) ?
                    CNT_W'(NUM_W) : '0;
      end else if (div_left != '0) begin
        div_left <= div_left - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1      <= q_item;
      div_rem <= '0;
      div_den <= {q_item.mag_b, 1'b0};
      div_num <= (NUM_W'(q_item.mag_a) << (F + 1)) + NUM_W'(q_item.mag_b);
    end else if (div_left != '0) begin
      div_rem <= rem_ge ? (W+1)'(rem_sh - {1'b0, div_den}) : rem_sh[W:0];
      div_num <= {div_num[NUM_W-2:0], rem_ge};
    end
  end

  assign prod = s1.mag_a * s1.mag_b;

  always_comb begin
    sa  = s1.a;
    ea  = {s1.a[W-1], s1.a};
    eb  = {s1.b[W-1], s1.b};
    sum = '0;
    s2_res_next     = '0;
    s2_st_next      = fpa_pkg::ST_OK;
    s2_use_mag_next = 1'b0;
    s2_round_next   = 1'b0;
    s2_mag_next     = '0;
    unique case (s1.op)
      fpa_pkg::OP_ADD, fpa_pkg::OP_SUB, fpa_pkg::OP_INC, fpa_pkg::OP_DEC: begin
        case (s1.op)
          fpa_pkg::OP_ADD: sum = ea + eb;
          fpa_pkg::OP_SUB: sum = ea - eb;
          fpa_pkg::OP_INC: sum = ea + (W+1)'(1);
          default:         sum = ea - (W+1)'(1);
        endcase
        if (sum[W] != sum[W-1]) begin
          s2_res_next = sum[W] ? fpa_pkg::WORD_MIN : fpa_pkg::WORD_MAX;
          s2_st_next  = fpa_pkg::ST_SAT;
        end else begin
          s2_res_next = fpa_pkg::word_t'(sum[W-1:0]);
        end
      end
      fpa_pkg::OP_MUL: begin
        s2_use_mag_next = 1'b1;
        s2_round_next   = 1'b1;
        s2_mag_next     = fpa_pkg::mag_t'(prod);
      end
      fpa_pkg::OP_DIV: begin
        if (s1.mag_b == '0) begin
          s2_st_next = fpa_pkg::ST_DIV0;
        end else begin
          s2_use_mag_next = 1'b1;
          s2_mag_next     = fpa_pkg::mag_t'(div_num);
        end
      end
      fpa_pkg::OP_CMP: s2_res_next = '0;
      fpa_pkg::OP_MIN: s2_res_next = s1.cmp.lt ? s1.a : s1.b;
      fpa_pkg::OP_FROM_INT: begin
        s2_use_mag_next = 1'b1;
        s2_mag_next     = fpa_pkg::mag_t'(s1.mag_a) << F;
      end
      fpa_pkg::OP_TO_INT: s2_res_next = sa >>> F;
      default: s2_res_next = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_load) begin
      s2_valid <= s1_valid && s1_done;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      s2_res     <= s2_res_next;
      s2_st      <= s2_st_next;
      s2_use_mag <= s2_use_mag_next;
      s2_round   <= s2_round_next;
      s2_neg     <= s1.neg;
      s2_mag     <= s2_mag_next;
      s2_cmp     <= s1.cmp;
    end
  end

  always_comb begin
    m       = s2_round ? (s2_mag + HALF) >> F : s2_mag;
    fin_res = s2_res;
    fin_st  = s2_st;
    if (s2_use_mag) begin
      if (s2_neg) begin
        if (m > LIM_NEG) begin
          fin_res = fpa_pkg::WORD_MIN;
          fin_st  = fpa_pkg::ST_SAT;
        end else begin
          fin_res = fpa_pkg::word_t'(fpa_pkg::umag_t'(0) - m[W-1:0]);
        end
      end else begin
        if (m > LIM_POS) begin
          fin_res = fpa_pkg::WORD_MAX;
          fin_st  = fpa_pkg::ST_SAT;
        end else begin
          fin_res = fpa_pkg::word_t'(m[W-1:0]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= fin_res;
      out_st  <= fin_st;
      out_cmp <= s2_cmp;
    end
  end

  assign result_value = 32'(out_res);
  assign a_less       = out_cmp.lt;
  assign a_equal      = out_cmp.eq;
  assign a_greater    = out_cmp.gt;
  assign status       = out_st;

  a_div_holds: assert property (@(posedge clk) disable iff (rst)
    div_left != '0 |-> s1_valid)
    else $error("divider running without an item");

  a_div_stays: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && div_left != '0) |=> (s1_valid && $stable(s1)))
    else $error("item left operand stage during divide");

  a_flags: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot({a_less, a_equal, a_greater}))
    else $error("compare flags not one-hot");

  a_div0: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == fpa_pkg::ST_DIV0) |-> result_value == '0)
    else $error("divide by zero with nonzero result");

endmodule

/* rtl/fixed_point_alu.sv */
// ----------------------------------------------------------------------------
// fixed_point_alu
// Signed Q fixed-point ALU: add, sub, mul, div, inc, dec, compare, min,
// int-to-fixed and fixed-to-int, with saturation and compare flags.
//
// Input channel: op, operand_a, operand_b qualified by in_valid; the item
// is taken on a clock edge with in_valid high and in_stall low.
// Output channel: result_value, a_less, a_equal, a_greater and status
// qualified by out_valid; the receiver holds it with out_stall.
// One result per item, in order.
// Path: input register, queue, operand stage, magnitude stage, output
// register. A divide by a nonzero divisor waits in the operand stage
// while the restoring divider forms WORD_BITS + FRACTION_BITS + 1
// quotient bits (41 by default), one quotient bit per cycle. Throughput:
// one item per cycle while out_stall is low; a divide holds the execute pipe.
// A two-entry queue sits between input register and execute pipe, so the
// input keeps taking items while a stalled result waits; when the receiver
// stalls long enough, the pipe and queue fill and in_stall rises.
// Reset empties all stages; no clearing pass.
// ----------------------------------------------------------------------------
module fixed_point_alu (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [3:0]         op,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] result_value,
  output logic               a_less,
  output logic               a_equal,
  output logic               a_greater,
  output logic [1:0]         status
);

  logic           push;
  fpa_pkg::item_t push_item;
  logic           full;
  logic           pop;
  logic           head_valid;
  fpa_pkg::item_t head_item;

  fpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .op        (op),
    .operand_a (operand_a),
    .operand_b (operand_b),
    .q_push    (push),
    .q_item    (push_item),
    .q_full    (full)
  );

  fpa_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_item  (push_item),
    .full       (full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  fpa_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_valid      (head_valid),
    .q_item       (head_item),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .result_value (result_value),
    .a_less       (a_less),
    .a_equal      (a_equal),
    .a_greater    (a_greater),
    .status       (status)
  );

endmodule
